// File: rtl/dtg_pkg.sv
package dtg_pkg;

  localparam int GRID_W_DEF     = 128;
  localparam int GRID_H_DEF     = 128;
  localparam int COUNT_BITS_DEF = 20;

  localparam int DEPTH_W  = 16;
  localparam int COLUMN_W = 12;
  localparam int CELL_W   = 7;
  localparam int COUNT_W  = 20;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // shared divider: lateral product magnitude over focal length or doubled cell side
  localparam int DIV_NUM_W = 28;
  localparam int DIV_DEN_W = 17;

  localparam logic [2:0] REG_FOCAL_PX      = 3'd0;
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd1;
  localparam logic [2:0] REG_MAP_WIDTH_MM  = 3'd2;
  localparam logic [2:0] REG_MAP_HEIGHT_MM = 3'd3;
  localparam logic [2:0] REG_CENTER_X_MM   = 3'd4;
  localparam logic [2:0] REG_CENTER_Y_MM   = 3'd5;
  localparam logic [2:0] REG_CELL_MM       = 3'd6;

  localparam logic [15:0] FOCAL_PX_RST      = 16'd525;
  localparam logic [11:0] IMAGE_WIDTH_RST   = 12'd640;
  localparam logic [15:0] MAP_WIDTH_MM_RST  = 16'd10000;
  localparam logic [15:0] MAP_HEIGHT_MM_RST = 16'd10000;
  localparam logic [15:0] CENTER_X_MM_RST   = 16'd0;
  localparam logic [15:0] CENTER_Y_MM_RST   = 16'd0;
  localparam logic [15:0] CELL_MM_RST       = 16'd100;

  typedef struct packed {
    logic [15:0] focal_px;
    logic [11:0] image_width;
    logic [15:0] map_width_mm;
    logic [15:0] map_height_mm;
    logic [15:0] center_x_mm;
    logic [15:0] center_y_mm;
    logic [15:0] cell_mm;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_LAT_GO,
    ST_LAT_WAIT,
    ST_RANGE,
    ST_X_GO,
    ST_X_WAIT,
    ST_Y_GO,
    ST_Y_WAIT,
    ST_CHECK,
    ST_READ,
    ST_MODIFY,
    ST_DONE
  } state_t;

endpackage

// File: rtl/dtg_regs.sv
module dtg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dtg_pkg::ADDR_W-1:0]  paddr,
  input  logic [dtg_pkg::DATA_W-1:0]  pwdata,
  output logic [dtg_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output dtg_pkg::cfg_t               cfg
);

  dtg_pkg::cfg_t cfg_r;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.focal_px      <= dtg_pkg::FOCAL_PX_RST;
      cfg_r.image_width   <= dtg_pkg::IMAGE_WIDTH_RST;
      cfg_r.map_width_mm  <= dtg_pkg::MAP_WIDTH_MM_RST;
      cfg_r.map_height_mm <= dtg_pkg::MAP_HEIGHT_MM_RST;
      cfg_r.center_x_mm   <= dtg_pkg::CENTER_X_MM_RST;
      cfg_r.center_y_mm   <= dtg_pkg::CENTER_Y_MM_RST;
      cfg_r.cell_mm       <= dtg_pkg::CELL_MM_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        dtg_pkg::REG_FOCAL_PX:      cfg_r.focal_px      <= pwdata[15:0];
        dtg_pkg::REG_IMAGE_WIDTH:   cfg_r.image_width   <= pwdata[11:0];
        dtg_pkg::REG_MAP_WIDTH_MM:  cfg_r.map_width_mm  <= pwdata[15:0];
        dtg_pkg::REG_MAP_HEIGHT_MM: cfg_r.map_height_mm <= pwdata[15:0];
        dtg_pkg::REG_CENTER_X_MM:   cfg_r.center_x_mm   <= pwdata[15:0];
        dtg_pkg::REG_CENTER_Y_MM:   cfg_r.center_y_mm   <= pwdata[15:0];
        dtg_pkg::REG_CELL_MM:       cfg_r.cell_mm       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      dtg_pkg::REG_FOCAL_PX:      prdata = {16'd0, cfg_r.focal_px};
      dtg_pkg::REG_IMAGE_WIDTH:   prdata = {20'd0, cfg_r.image_width};
      dtg_pkg::REG_MAP_WIDTH_MM:  prdata = {16'd0, cfg_r.map_width_mm};
      dtg_pkg::REG_MAP_HEIGHT_MM: prdata = {16'd0, cfg_r.map_height_mm};
      dtg_pkg::REG_CENTER_X_MM:   prdata = {16'd0, cfg_r.center_x_mm};
      dtg_pkg::REG_CENTER_Y_MM:   prdata = {16'd0, cfg_r.center_y_mm};
      dtg_pkg::REG_CELL_MM:       prdata = {16'd0, cfg_r.cell_mm};
      default:                    prdata = '0;
    endcase
  end

endmodule

// File: rtl/dtg_div.sv
module dtg_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dtg_pkg::DIV_NUM_W-1:0] num,
  input  logic [dtg_pkg::DIV_DEN_W-1:0] den,
  output logic                          done,
  output logic [dtg_pkg::DIV_NUM_W-1:0] quo
);

  localparam int NW = dtg_pkg::DIV_NUM_W;
  localparam int DW = dtg_pkg::DIV_DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] rem_nxt;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   rem_sh;
  logic [DW+1:0] diff;
  logic          ge;

  // restoring division, one quotient bit per cycle
  assign rem_sh  = {rem_r, quo_r[NW-1]};
  assign diff    = {1'b0, rem_sh} - {2'b00, den_r};
  assign ge      = ~diff[DW+1];
  assign rem_nxt = ge ? diff[DW-1:0] : rem_sh[DW-1:0];

  assign done = done_r;
  assign quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

endmodule

// File: rtl/dtg_cnt_ram.sv
module dtg_cnt_ram #(
  parameter int DEPTH = dtg_pkg::GRID_W_DEF * dtg_pkg::GRID_H_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = dtg_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// File: rtl/depth_to_grid_histogram.sv
// channel  | direction | handshake                | payload
// ---------+-----------+--------------------------+---------------------------------------
// in       | input     | in_valid / in_ready      | in_kind, in_depth_mm, in_column,
//          |           |                          | in_read_x, in_read_y
// out      | output    | out_valid / out_ready    | out_mapped, out_cell_x, out_cell_y,
//          |           |                          | out_count
// config   | input     | psel, penable, pwrite    | paddr, pwdata, prdata, pready
//
// one item at a time: a mapped pixel needs three passes of the shared bit-serial divider,
// one per 28-bit quotient (lateral offset, cell x, cell y)
// a cell read and a pixel with zero depth do not use the divider
// after reset a clearing pass writes zero to all GRID_W*GRID_H counter entries, one a cycle;
// no item is accepted until it ends
// the result register lets a new item be accepted while the previous result waits on out_ready
module depth_to_grid_histogram #(
  parameter int GRID_W     = dtg_pkg::GRID_W_DEF,
  parameter int GRID_H     = dtg_pkg::GRID_H_DEF,
  parameter int COUNT_BITS = dtg_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [dtg_pkg::DEPTH_W-1:0]   in_depth_mm,
  input  logic [dtg_pkg::COLUMN_W-1:0]  in_column,
  input  logic [dtg_pkg::CELL_W-1:0]    in_read_x,
  input  logic [dtg_pkg::CELL_W-1:0]    in_read_y,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_mapped,
  output logic [dtg_pkg::CELL_W-1:0]    out_cell_x,
  output logic [dtg_pkg::CELL_W-1:0]    out_cell_y,
  output logic [dtg_pkg::COUNT_W-1:0]   out_count,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtg_pkg::ADDR_W-1:0]    paddr,
  input  logic [dtg_pkg::DATA_W-1:0]    pwdata,
  output logic [dtg_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int DEPTH  = GRID_W * GRID_H;
  localparam int AW     = $clog2(DEPTH);
  localparam int NW     = dtg_pkg::DIV_NUM_W;
  localparam int DW     = dtg_pkg::DIV_DEN_W;
  localparam int PROD_W = 30;
  localparam int CW     = dtg_pkg::CELL_W;

  dtg_pkg::cfg_t   cfg;
  dtg_pkg::state_t state_r;
  dtg_pkg::state_t state_nxt;

  logic                         kind_r;
  logic [dtg_pkg::DEPTH_W-1:0]  depth_r;
  logic [dtg_pkg::COLUMN_W-1:0] column_r;
  logic [CW-1:0]                rx_r;
  logic [CW-1:0]                ry_r;

  logic signed [PROD_W-1:0]     prod_r;
  logic signed [PROD_W-1:0]     prod_nxt;
  logic signed [12:0]           col_off;
  logic [PROD_W-1:0]            prod_mag;
  logic signed [NW:0]           lateral_r;
  logic [DW-1:0]                px2_r;
  logic [DW-1:0]                py2_r;
  logic [DW-1:0]                xg_r;
  logic [DW-1:0]                yg_r;
  logic [AW-1:0]                mem_addr_r;
  logic [AW-1:0]                clr_addr_r;
  logic                         clr_last;

  logic [19:0]                  px2;
  logic [19:0]                  px_off;
  logic [31:0]                  py2;
  logic [31:0]                  py_off;
  logic                         in_map;
  logic                         in_grid;

  logic [15:0]                  focal_eff;
  logic [DW-1:0]                cell2;

  logic                         div_start;
  logic [NW-1:0]                div_num;
  logic [DW-1:0]                div_den;
  logic                         div_done;
  logic [NW-1:0]                div_quo;

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [COUNT_BITS-1:0]        mem_wdata;
  logic                         mem_re;
  logic [COUNT_BITS-1:0]        mem_rdata;
  logic [COUNT_BITS-1:0]        cnt_inc;

  logic                         res_mapped_r;
  logic [dtg_pkg::COUNT_W-1:0]  res_count_r;
  logic                         out_free;

  logic                         out_valid_r;
  logic                         out_mapped_r;
  logic [CW-1:0]                out_cell_x_r;
  logic [CW-1:0]                out_cell_y_r;
  logic [dtg_pkg::COUNT_W-1:0]  out_count_r;

  dtg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dtg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  dtg_cnt_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (COUNT_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_addr_r),
    .rdata (mem_rdata)
  );

  // geometry
  assign focal_eff = (cfg.focal_px == 16'd0) ? 16'd1 : cfg.focal_px;
  assign cell2     = (cfg.cell_mm == 16'd0) ? DW'(2) : {cfg.cell_mm, 1'b0};

  assign col_off  = $signed({1'b0, column_r}) - $signed({2'b00, cfg.image_width[11:1]});
  assign prod_nxt = PROD_W'(col_off * $signed({1'b0, depth_r}));
  assign prod_mag = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : prod_r;

  assign px_off = {4'd0, depth_r} - {{4{cfg.center_x_mm[15]}}, cfg.center_x_mm};
  assign px2    = {4'd0, cfg.map_width_mm} + {px_off[18:0], 1'b0};
  assign py_off = {{(32-NW-1){lateral_r[NW]}}, lateral_r}
                - {{16{cfg.center_y_mm[15]}}, cfg.center_y_mm};
  assign py2    = {16'd0, cfg.map_height_mm} - {py_off[30:0], 1'b0};

  assign in_map = ~px2[19] && (px2 < {3'd0, cfg.map_width_mm, 1'b0})
               && ~py2[31] && (py2 < {15'd0, cfg.map_height_mm, 1'b0});
  assign in_grid = (32'(xg_r) < 32'(GRID_W)) && (32'(yg_r) < 32'(GRID_H));

  assign cnt_inc  = (&mem_rdata) ? mem_rdata : mem_rdata + 1'b1;
  assign clr_last = (clr_addr_r == AW'(DEPTH - 1));
  assign out_free = ~out_valid_r | out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dtg_pkg::ST_CLEAR:    if (clr_last) state_nxt = dtg_pkg::ST_IDLE;
      dtg_pkg::ST_IDLE:     if (in_valid) state_nxt = dtg_pkg::ST_PREP;
      dtg_pkg::ST_PREP: begin
        priority if (kind_r)              state_nxt = dtg_pkg::ST_CHECK;
        else if (depth_r == '0)           state_nxt = dtg_pkg::ST_DONE;
        else                              state_nxt = dtg_pkg::ST_LAT_GO;
      end
      dtg_pkg::ST_LAT_GO:   state_nxt = dtg_pkg::ST_LAT_WAIT;
      dtg_pkg::ST_LAT_WAIT: if (div_done) state_nxt = dtg_pkg::ST_RANGE;
      dtg_pkg::ST_RANGE:    state_nxt = in_map ? dtg_pkg::ST_X_GO : dtg_pkg::ST_DONE;
      dtg_pkg::ST_X_GO:     state_nxt = dtg_pkg::ST_X_WAIT;
      dtg_pkg::ST_X_WAIT:   if (div_done) state_nxt = dtg_pkg::ST_Y_GO;
      dtg_pkg::ST_Y_GO:     state_nxt = dtg_pkg::ST_Y_WAIT;
      dtg_pkg::ST_Y_WAIT:   if (div_done) state_nxt = dtg_pkg::ST_CHECK;
      dtg_pkg::ST_CHECK:    state_nxt = in_grid ? dtg_pkg::ST_READ : dtg_pkg::ST_DONE;
      dtg_pkg::ST_READ:     state_nxt = dtg_pkg::ST_MODIFY;
      dtg_pkg::ST_MODIFY:   state_nxt = dtg_pkg::ST_DONE;
      dtg_pkg::ST_DONE:     if (out_free) state_nxt = dtg_pkg::ST_IDLE;
      default:              state_nxt = dtg_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    div_num   = prod_mag[NW-1:0];
    div_den   = {1'b0, focal_eff};
    mem_we    = 1'b0;
    mem_waddr = mem_addr_r;
    mem_wdata = '0;
    mem_re    = 1'b0;
    unique case (state_r)
      dtg_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
      end
      dtg_pkg::ST_IDLE:   in_ready = 1'b1;
      dtg_pkg::ST_LAT_GO: div_start = 1'b1;
      dtg_pkg::ST_X_GO: begin
        div_start = 1'b1;
        div_num   = NW'(px2_r);
        div_den   = cell2;
      end
      dtg_pkg::ST_Y_GO: begin
        div_start = 1'b1;
        div_num   = NW'(py2_r);
        div_den   = cell2;
      end
      dtg_pkg::ST_READ:   mem_re = 1'b1;
      dtg_pkg::ST_MODIFY: begin
        mem_we    = 1'b1;
        mem_wdata = kind_r ? '0 : cnt_inc;
      end
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dtg_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == dtg_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (state_r == dtg_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      dtg_pkg::ST_IDLE: begin
        kind_r   <= in_kind;
        depth_r  <= in_depth_mm;
        column_r <= in_column;
        rx_r     <= in_read_x;
        ry_r     <= in_read_y;
      end
      dtg_pkg::ST_PREP: begin
        res_mapped_r <= 1'b0;
        res_count_r  <= '0;
        prod_r       <= prod_nxt;
        xg_r         <= DW'(rx_r);
        yg_r         <= DW'(ry_r);
      end
      dtg_pkg::ST_LAT_WAIT: begin
        if (div_done) begin
          lateral_r <= prod_r[PROD_W-1] ? -$signed({1'b0, div_quo})
                                        : $signed({1'b0, div_quo});
        end
      end
      dtg_pkg::ST_RANGE: begin
        px2_r <= px2[DW-1:0];
        py2_r <= py2[DW-1:0];
      end
      dtg_pkg::ST_X_WAIT: if (div_done) xg_r <= div_quo[DW-1:0];
      dtg_pkg::ST_Y_WAIT: if (div_done) yg_r <= div_quo[DW-1:0];
      dtg_pkg::ST_CHECK: mem_addr_r <= AW'(32'(yg_r) * 32'(GRID_W) + 32'(xg_r));
      dtg_pkg::ST_MODIFY: begin
        res_mapped_r <= 1'b1;
        res_count_r  <= kind_r ? dtg_pkg::COUNT_W'(mem_rdata) : dtg_pkg::COUNT_W'(cnt_inc);
      end
      dtg_pkg::ST_DONE: begin
        if (out_free) begin
          out_mapped_r <= res_mapped_r;
          out_cell_x_r <= res_mapped_r ? xg_r[CW-1:0] : '0;
          out_cell_y_r <= res_mapped_r ? yg_r[CW-1:0] : '0;
          out_count_r  <= res_count_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_mapped = out_mapped_r;
  assign out_cell_x = out_cell_x_r;
  assign out_cell_y = out_cell_y_r;
  assign out_count  = out_count_r;

endmodule

// File: sim/depth_to_grid_histogram_test.sv
module depth_to_grid_histogram_test;

  typedef struct packed {
    logic                        mapped;
    logic [dtg_pkg::CELL_W-1:0]  cell_x;
    logic [dtg_pkg::CELL_W-1:0]  cell_y;
    logic [dtg_pkg::COUNT_W-1:0] count;
  } cell_result_t;

  localparam int GRID_SIDE = 128;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_kind;
  logic [dtg_pkg::DEPTH_W-1:0]  in_depth_mm;
  logic [dtg_pkg::COLUMN_W-1:0] in_column;
  logic [dtg_pkg::CELL_W-1:0]   in_read_x;
  logic [dtg_pkg::CELL_W-1:0]   in_read_y;
  logic                         out_valid;
  logic                         out_ready;
  logic                         out_mapped;
  logic [dtg_pkg::CELL_W-1:0]   out_cell_x;
  logic [dtg_pkg::CELL_W-1:0]   out_cell_y;
  logic [dtg_pkg::COUNT_W-1:0]  out_count;
  logic                         cfg_psel;
  logic                         cfg_penable;
  logic                         cfg_pwrite;
  logic [dtg_pkg::ADDR_W-1:0]   cfg_paddr;
  logic [dtg_pkg::DATA_W-1:0]   cfg_pwdata;
  logic [dtg_pkg::DATA_W-1:0]   cfg_prdata;
  logic                         cfg_pready;

  // model of the grid and its settings
  logic [dtg_pkg::COUNT_W-1:0] grid_counts [0:GRID_SIDE*GRID_SIDE-1];
  longint focal_px, image_width, map_width_mm, map_height_mm;
  longint center_x_mm, center_y_mm, cell_mm;

  cell_result_t                 expected_cells[$];
  logic [2*dtg_pkg::CELL_W-1:0] recent_cells[$];

  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int n_checked;
  int n_binned;
  int n_dropped;
  int n_reads;
  int n_settings;

  depth_to_grid_histogram DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_depth_mm(in_depth_mm),
    .in_column  (in_column),
    .in_read_x  (in_read_x),
    .in_read_y  (in_read_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_mapped (out_mapped),
    .out_cell_x (out_cell_x),
    .out_cell_y (out_cell_y),
    .out_count  (out_count),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
    error_count++;
    if (error_count <= 100) begin
      $display("mismatch on %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $time);
    end
  endtask

  // project one transaction onto the grid and update the cell counts
  function automatic cell_result_t bin_depth_pixel(input logic kind, input logic [15:0] depth,
                                                   input logic [11:0] column,
                                                   input logic [6:0] rx, input logic [6:0] ry);
    cell_result_t r;
    longint f, cell2, lateral, px2, py2, xg, yg;
    int idx;
    r = '0;
    if (kind) begin
      idx = int'({ry, rx});
      r.mapped = 1'b1;
      r.cell_x = rx;
      r.cell_y = ry;
      r.count = grid_counts[idx];
      grid_counts[idx] = '0;
      return r;
    end
    if (depth == 0) return r;
    f = (focal_px != 0) ? focal_px : 1;
    cell2 = 2 * ((cell_mm != 0) ? cell_mm : 1);
    lateral = ((longint'(column) - image_width / 2) * longint'(depth)) / f;
    px2 = map_width_mm + 2 * (longint'(depth) - center_x_mm);
    py2 = map_height_mm - 2 * (lateral - center_y_mm);
    if (px2 < 0 || px2 >= 2 * map_width_mm || py2 < 0 || py2 >= 2 * map_height_mm) return r;
    xg = px2 / cell2;
    yg = py2 / cell2;
    if (xg >= GRID_SIDE || yg >= GRID_SIDE) return r;
    idx = int'(yg) * GRID_SIDE + int'(xg);
    if (grid_counts[idx] != '1) grid_counts[idx] = grid_counts[idx] + 1'b1;
    r.mapped = 1'b1;
    r.cell_x = xg[6:0];
    r.cell_y = yg[6:0];
    r.count = grid_counts[idx];
    return r;
  endfunction

  task automatic send_item(input logic kind, input logic [15:0] depth, input logic [11:0] column,
                           input logic [6:0] rx, input logic [6:0] ry);
    cell_result_t r;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    if (send_idle_pct != 0 && $urandom_range(63) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(110, 1)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_kind = kind;
    in_depth_mm = depth;
    in_column = column;
    in_read_x = rx;
    in_read_y = ry;
    do @(posedge clk); while (!in_ready);
    r = bin_depth_pixel(kind, depth, column, rx, ry);
    expected_cells.push_back(r);
    if (kind) begin
      n_reads++;
    end else if (r.mapped) begin
      n_binned++;
      recent_cells.push_back({r.cell_y, r.cell_x});
      if (recent_cells.size() > 32) void'(recent_cells.pop_front());
    end else begin
      n_dropped++;
    end
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    cell_result_t e;
    if (rst_n && out_valid && out_ready) begin
      n_checked++;
      if (expected_cells.size() == 0) begin
        report_mismatch("transaction with nothing pending", -1, out_count);
      end else begin
        e = expected_cells.pop_front();
        if (out_mapped !== e.mapped) report_mismatch("mapped", e.mapped, out_mapped);
        if (out_cell_x !== e.cell_x) report_mismatch("cell_x", e.cell_x, out_cell_x);
        if (out_cell_y !== e.cell_y) report_mismatch("cell_y", e.cell_y, out_cell_y);
        if (out_count !== e.count) report_mismatch("count", e.count, out_count);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      dtg_pkg::REG_FOCAL_PX:      focal_px = value[15:0];
      dtg_pkg::REG_IMAGE_WIDTH:   image_width = value[11:0];
      dtg_pkg::REG_MAP_WIDTH_MM:  map_width_mm = value[15:0];
      dtg_pkg::REG_MAP_HEIGHT_MM: map_height_mm = value[15:0];
      dtg_pkg::REG_CENTER_X_MM:   center_x_mm = $signed(value[15:0]);
      dtg_pkg::REG_CENTER_Y_MM:   center_y_mm = $signed(value[15:0]);
      dtg_pkg::REG_CELL_MM:       cell_mm = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  // drain the block, then load a full register set
  task automatic apply_setting(input logic [31:0] focal, input logic [31:0] width,
                               input logic [31:0] map_w, input logic [31:0] map_h,
                               input logic [31:0] cx, input logic [31:0] cy,
                               input logic [31:0] cell_side);
    in_valid = 1'b0;
    while (expected_cells.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    write_reg(dtg_pkg::REG_FOCAL_PX, focal);
    write_reg(dtg_pkg::REG_IMAGE_WIDTH, width);
    write_reg(dtg_pkg::REG_MAP_WIDTH_MM, map_w);
    write_reg(dtg_pkg::REG_MAP_HEIGHT_MM, map_h);
    write_reg(dtg_pkg::REG_CENTER_X_MM, cx);
    write_reg(dtg_pkg::REG_CENTER_Y_MM, cy);
    write_reg(dtg_pkg::REG_CELL_MM, cell_side);
    recent_cells.delete();
    n_settings++;
  endtask

  // pick a depth and column that land inside the current map most of the time
  task automatic aim_pixel(output logic [15:0] depth, output logic [11:0] column);
    longint t, d, lat, c, f;
    f = (focal_px != 0) ? focal_px : 1;
    t = (map_width_mm > 0) ? longint'($urandom_range(2 * map_width_mm - 1)) : 0;
    d = center_x_mm + (t - map_width_mm) / 2;
    if (d < 1 || d > 65535) d = $urandom_range(65535, 1);
    t = (map_height_mm > 0) ? longint'($urandom_range(2 * map_height_mm - 1)) : 0;
    lat = center_y_mm + (map_height_mm - t) / 2;
    c = image_width / 2 + lat * f / d;
    if (c < 0) c = 0;
    if (c > 4095) c = 4095;
    depth = d[15:0];
    column = c[11:0];
  endtask

  task automatic run_random(input int n);
    int pick;
    logic kind;
    logic [15:0] depth;
    logic [11:0] column;
    logic [6:0] rx, ry;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      kind = 1'b0;
      depth = $urandom_range(65535);
      column = $urandom_range(4095);
      rx = $urandom_range(127);
      ry = $urandom_range(127);
      if (pick < 12) begin
        kind = 1'b1;
        if (recent_cells.size() != 0 && $urandom_range(1)) begin
          {ry, rx} = recent_cells[$urandom_range(recent_cells.size() - 1)];
        end
      end else if (pick < 17) begin
        depth = '0;
      end else if (pick >= 32) begin
        aim_pixel(depth, column);
      end
      send_item(kind, depth, column, rx, ry);
    end
  endtask

  task automatic test_directed_defaults;
    send_item(1'b0, 16'd1000, 12'd320, 7'd0, 7'd0);
    send_item(1'b0, 16'd1000, 12'd320, 7'd127, 7'd127);
    send_item(1'b1, 16'd0, 12'd0, 7'd60, 7'd50);
    send_item(1'b1, 16'hFFFF, 12'hFFF, 7'd60, 7'd50);
    send_item(1'b0, 16'd0, 12'd100, 7'd0, 7'd0);
    send_item(1'b1, 16'hFFFF, 12'hFFF, 7'd127, 7'd127);
    send_item(1'b1, 16'd0, 12'd0, 7'd0, 7'd0);
    send_item(1'b0, 16'hFFFF, 12'd0, 7'd0, 7'd0);
    send_item(1'b0, 16'd4999, 12'd320, 7'd0, 7'd0);
    send_item(1'b0, 16'd5000, 12'd320, 7'd0, 7'd0);
    // lateral edge: py2 of zero is in, one step further is out
    send_item(1'b0, 16'd1050, 12'd2820, 7'd0, 7'd0);
    send_item(1'b0, 16'd1050, 12'd2821, 7'd0, 7'd0);
    // negative lateral truncates toward zero
    send_item(1'b0, 16'd1000, 12'd0, 7'd0, 7'd0);
    send_item(1'b0, 16'd1, 12'hFFF, 7'd0, 7'd0);
    send_item(1'b0, 16'd1, 12'd0, 7'd0, 7'd0);
    send_item(1'b1, 16'd0, 12'd0, 7'd49, 7'd50);
  endtask

  task automatic test_beyond_grid;
    apply_setting(300, 320, 2000, 3000, 1500, -200, 10);
    send_item(1'b0, 16'd500, 12'd173, 7'd0, 7'd0);
    send_item(1'b0, 16'd500, 12'd172, 7'd0, 7'd0);
    send_item(1'b0, 16'd1800, 12'd173, 7'd0, 7'd0);
    send_item(1'b0, 16'd1739, 12'd173, 7'd0, 7'd0);
    send_item(1'b0, 16'd2499, 12'd173, 7'd0, 7'd0);
    send_item(1'b1, 16'd0, 12'd0, 7'd123, 7'd127);
    run_random(150);
  endtask

  task automatic test_default_random;
    apply_setting(525, 640, 10000, 10000, 0, 0, 100);
    run_random(350);
  endtask

  task automatic test_register_extremes;
    // upper bits of the image width write must be dropped
    apply_setting(65535, 32'hFFFF_FFFF, 65535, 65535, 32767, 32767, 65535);
    run_random(150);
    apply_setting(1, 1, 1, 1, 32'hFFFF_8000, 32'hFFFF_8000, 1);
    run_random(40);
  endtask

  task automatic test_zero_divisors;
    apply_setting(0, 0, 256, 256, 100, 0, 0);
    run_random(150);
  endtask

  task automatic test_offset_map;
    apply_setting(600, 1280, 12800, 6400, 6000, -1000, 100);
    run_random(350);
    apply_setting(1000, 1001, 65535, 65535, 32767, -5000, 600);
    run_random(250);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = 1'b0;
    in_depth_mm = '0;
    in_column = '0;
    in_read_x = '0;
    in_read_y = '0;
    out_ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    error_count = 0;
    n_checked = 0;
    n_binned = 0;
    n_dropped = 0;
    n_reads = 0;
    n_settings = 0;
    focal_px = dtg_pkg::FOCAL_PX_RST;
    image_width = dtg_pkg::IMAGE_WIDTH_RST;
    map_width_mm = dtg_pkg::MAP_WIDTH_MM_RST;
    map_height_mm = dtg_pkg::MAP_HEIGHT_MM_RST;
    center_x_mm = $signed(dtg_pkg::CENTER_X_MM_RST);
    center_y_mm = $signed(dtg_pkg::CENTER_Y_MM_RST);
    cell_mm = dtg_pkg::CELL_MM_RST;
    for (int i = 0; i < GRID_SIDE * GRID_SIDE; i++) grid_counts[i] = '0;
    send_idle_pct = 8;
    recv_idle_pct = 55;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_defaults();
    test_beyond_grid();
    test_default_random();
    send_idle_pct = 55;
    recv_idle_pct = 8;
    test_register_extremes();
    test_zero_divisors();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_offset_map();

    in_valid = 1'b0;
    while (expected_cells.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    $display("checked %0d transactions: %0d pixels binned, %0d dropped, %0d cell reads",
             n_checked, n_binned, n_dropped, n_reads);
    $display("register sets loaded after reset defaults: %0d", n_settings);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("timeout with %0d transactions pending", expected_cells.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
